// ===== hdl/csum_pkg.sv =====
// Shared types and constants for the ones-complement checksum stream.
// No dependencies; imported by every module of the block.
package csum_pkg;

   localparam logic [7:0] UDP_PROTO  = 8'h11;
   localparam logic [7:0] LEN_OFFSET = 8'd8;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } csum_req_type;

   typedef struct packed {
      logic [15:0] plain_checksum;
      logic [15:0] udp_checksum;
      logic [15:0] byte_count;
   } csum_rsp_type;

   // finished packet handed from the accumulator to the fold pipeline
   typedef struct packed {
      logic [31:0] sum;
      logic [15:0] count;
   } csum_fin_type;

endpackage

// ===== hdl/ones_complement_checksum_stream.sv =====
// Ones-complement (Internet) checksum over a byte stream, plain and UDP-adjusted.
// Throughput: one byte per cycle while req_stall is low.
// Result path: the last byte's sum passes the holding register, the fold stage
// and the output register, each of which back-pressure can hold.
// Reset: synchronous, active high; clears sum, count, valids; word phase set to high.
module ones_complement_checksum_stream
   import csum_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  csum_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output csum_rsp_type rsp_data
);

   logic         fin_valid;
   logic         fin_take;
   csum_fin_type fin;

   csum_acc u_acc (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .fin_valid (fin_valid),
      .fin       (fin),
      .fin_take  (fin_take)
   );

   csum_fold u_fold (
      .clock     (clock),
      .reset     (reset),
      .fin_valid (fin_valid),
      .fin       (fin),
      .fin_take  (fin_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a last beat always leaves a finished packet waiting
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.last |=> fin_valid)
      else $error("last beat did not produce a finished packet");

   assert property (@(posedge clock) disable iff (reset)
      fin_take |-> fin_valid)
      else $error("fold stage took an empty holding register");

   // every packet holds at least its last byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.byte_count != 16'd0)
      else $error("result beat with zero byte count");

endmodule

// ===== hdl/csum_acc.sv =====
// Byte accumulator: 32-bit end-around-carry sum, saturating byte count, word phase.
// Depends on csum_pkg; hands each finished packet on through a holding register.
module csum_acc
   import csum_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  csum_req_type req_data,
   output logic         fin_valid,
   output csum_fin_type fin,
   input  logic         fin_take
);

   logic [31:0]  sum_ff, sum_in;
   logic [15:0]  count_ff, count_in;
   logic         high_ff;
   logic         fin_valid_ff;
   csum_fin_type fin_ff;
   logic         take;
   logic [31:0]  addend;
   logic [32:0]  wide;

   assign req_stall = fin_valid_ff && !fin_take;
   assign take      = req_valid && !req_stall;
   assign fin_valid = fin_valid_ff;
   assign fin       = fin_ff;

   always_comb begin
      addend   = high_ff ? {16'd0, req_data.data_byte, 8'd0} : {24'd0, req_data.data_byte};
      wide     = {1'b0, sum_ff} + {1'b0, addend};
      // carry out of bit 31 wraps back in at bit 0
      sum_in   = wide[31:0] + {31'd0, wide[32]};
      count_in = (count_ff == 16'hFFFF) ? count_ff : count_ff + 16'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         high_ff      <= 1'b1;
         fin_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            if (req_data.last) begin
               sum_ff   <= '0;
               count_ff <= '0;
               high_ff  <= 1'b1;
            end else begin
               sum_ff   <= sum_in;
               count_ff <= count_in;
               high_ff  <= !high_ff;
            end
         end
         if (take && req_data.last) begin
            fin_valid_ff <= 1'b1;
         end else if (fin_take) begin
            fin_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_data.last) begin
         fin_ff.sum   <= sum_in;
         fin_ff.count <= count_in;
      end
   end

endmodule

// ===== hdl/csum_fold.sv =====
// Two-stage fold pipeline: UDP adjustment, 16-bit folds, inversion, output register.
// Depends on csum_pkg; fed by csum_acc.
module csum_fold
   import csum_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fin_valid,
   input  csum_fin_type fin,
   output logic         fin_take,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output csum_rsp_type rsp_data
);

   localparam logic [32:0] UdpAdjust = 33'(UDP_PROTO) - 33'(LEN_OFFSET);

   logic         s1_valid_ff;
   logic [16:0]  plain_ff, plain_in;
   logic [32:0]  udp_ff, udp_in;
   logic [15:0]  count_ff;
   logic         out_valid_ff;
   csum_rsp_type rsp_ff, rsp_in;
   logic         out_load;
   logic [16:0]  p2;
   logic [17:0]  u1;
   logic [16:0]  u2;
   logic [16:0]  u3;

   assign out_load  = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign fin_take  = fin_valid && (!s1_valid_ff || out_load);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      plain_in = {1'b0, fin.sum[15:0]} + {1'b0, fin.sum[31:16]};
      udp_in   = {1'b0, fin.sum} + {17'd0, fin.count} + UdpAdjust;
   end

   always_comb begin
      p2 = {1'b0, plain_ff[15:0]} + {16'd0, plain_ff[16]};
      // up to three folds for the 33-bit UDP sum
      u1 = {2'd0, udp_ff[15:0]} + {1'b0, udp_ff[32:16]};
      u2 = {1'b0, u1[15:0]} + {15'd0, u1[17:16]};
      u3 = {1'b0, u2[15:0]} + {16'd0, u2[16]};
      rsp_in.plain_checksum = ~p2[15:0];
      rsp_in.udp_checksum   = ~u3[15:0];
      rsp_in.byte_count     = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (fin_take) begin
            s1_valid_ff <= 1'b1;
         end else if (out_load) begin
            s1_valid_ff <= 1'b0;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fin_take) begin
         plain_ff <= plain_in;
         udp_ff   <= udp_in;
         count_ff <= fin.count;
      end
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for ones_complement_checksum_stream: byte packets are queued, driven beat by beat
// and every result beat is checked against an in-bench checksum predictor.
// Depends on csum_pkg and the block's RTL only.
module tb_top;
   import csum_pkg::*;

   typedef struct {
      csum_req_type beat;
      int unsigned  gap_after;
      bit           drain;
   } byte_item_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   csum_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   csum_rsp_type rsp_data;

   byte_item_type byte_q[$];
   logic [7:0]    pkt_buf[$];
   csum_rsp_type  csum_exp_q[$];

   int unsigned err_cnt = 0;
   int unsigned beats_in = 0;
   int unsigned hold_at = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned quiet_left = 0;
   bit          long_hold_done = 1'b0;

   // predictor state
   logic [31:0] acc_sum = '0;
   logic [15:0] acc_count = '0;
   logic        acc_hi_next = 1'b1;

   ones_complement_checksum_stream dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("Regression FAIL");
      $finish;
   end

   task automatic report_error(input string msg);
      err_cnt++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) report_error($sformatf("%s got %h want %h", name, got, want));
   endtask

   function automatic logic [15:0] fold_to_16(input logic [33:0] x);
      logic [33:0] v;
      v = x;
      while (v[33:16] != '0) v = {18'd0, v[15:0]} + {16'd0, v[33:16]};
      return v[15:0];
   endfunction

   // adds one byte into the running sum; on the last byte queues the expected beat
   function automatic void absorb_byte(input csum_req_type beat);
      logic [32:0]  wide;
      logic [33:0]  udp_sum;
      csum_rsp_type res;
      wide = {1'b0, acc_sum} + (acc_hi_next ? {17'd0, beat.data_byte, 8'd0}
                                            : {25'd0, beat.data_byte});
      // end-around carry
      acc_sum = wide[31:0] + {31'd0, wide[32]};
      acc_hi_next = ~acc_hi_next;
      if (acc_count != 16'hFFFF) acc_count = acc_count + 16'd1;
      if (beat.last) begin
         udp_sum = {2'd0, acc_sum} + {26'd0, UDP_PROTO} + {18'd0, acc_count}
                 - {26'd0, LEN_OFFSET};
         res.plain_checksum = ~fold_to_16({2'd0, acc_sum});
         res.udp_checksum = ~fold_to_16(udp_sum);
         res.byte_count = acc_count;
         csum_exp_q.push_back(res);
         acc_sum = '0;
         acc_count = '0;
         acc_hi_next = 1'b1;
      end
   endfunction

   function automatic int unsigned pick_gap(input bit quiet);
      int unsigned r;
      r = $urandom_range(99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic void flush_packet(input bit drain, input bit quiet);
      byte_item_type it;
      foreach (pkt_buf[i]) begin
         it.beat.data_byte = pkt_buf[i];
         it.beat.last = (i == pkt_buf.size() - 1);
         it.gap_after = pick_gap(quiet);
         it.drain = drain && (i == 0);
         byte_q.push_back(it);
      end
      pkt_buf.delete();
   endfunction

   // sender: a beat stays put until accepted, then the next one follows its gap
   always @(posedge clock) begin : drive_proc
      byte_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_byte(req_data);
            beats_in <= beats_in + 1;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left = gap_left - 1;
               req_valid <= 1'b0;
            end else if (byte_q.size() == 0
                         || (byte_q[0].drain && csum_exp_q.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               nxt = byte_q.pop_front();
               req_data <= nxt.beat;
               req_valid <= 1'b1;
               gap_left = nxt.gap_after;
            end
         end
      end
   end

   // receiver: checks each accepted beat and throttles with rsp_stall
   always @(posedge clock) begin : check_proc
      csum_rsp_type want;
      int unsigned  r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (csum_exp_q.size() == 0) begin
               report_error($sformatf("unexpected result beat %h", rsp_data));
            end else begin
               want = csum_exp_q.pop_front();
               check_field("plain_checksum", rsp_data.plain_checksum, want.plain_checksum);
               check_field("udp_checksum", rsp_data.udp_checksum, want.udp_checksum);
               check_field("byte_count", rsp_data.byte_count, want.byte_count);
            end
         end
         // one long hold-off while a burst of one-byte packets is offered
         if (!long_hold_done && hold_at != 0 && beats_in >= hold_at) begin
            long_hold_done = 1'b1;
            stall_left = 400;
         end
         if (stall_left != 0) begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (quiet_left != 0) begin
            quiet_left = quiet_left - 1;
            rsp_stall <= 1'b0;
         end else begin
            r = $urandom_range(99);
            if (r < 8) begin
               quiet_left = $urandom_range(20, 80);
               rsp_stall <= 1'b0;
            end else if (r < 60) begin
               rsp_stall <= 1'b0;
            end else if (r < 95) begin
               stall_left = $urandom_range(0, 2);
               rsp_stall <= 1'b1;
            end else begin
               stall_left = $urandom_range(4, 40);
               rsp_stall <= 1'b1;
            end
         end
      end
   end

   initial begin : stim_proc
      int unsigned rand_items;
      int unsigned npkt;
      int unsigned len;
      int unsigned r;

      // directed packets
      pkt_buf = '{8'h00};
      flush_packet(1'b1, 1'b0);
      pkt_buf = '{8'hFF};
      flush_packet(1'b0, 1'b0);
      // folded sum of all ones gives a zero checksum
      pkt_buf = '{8'hFF, 8'hFF};
      flush_packet(1'b0, 1'b0);
      // zero UDP checksum: 0xFFF4 plus the length adjustment of 11
      pkt_buf = '{8'hFF, 8'hF4};
      flush_packet(1'b0, 1'b1);
      // odd length, lone byte padded as high half
      pkt_buf = '{8'h12, 8'h34, 8'h56};
      flush_packet(1'b0, 1'b0);
      // carry out of 16 bits during the fold
      pkt_buf = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
      flush_packet(1'b0, 1'b1);
      pkt_buf = '{8'h80, 8'h01, 8'h7F, 8'hFE, 8'h00, 8'hAA, 8'h55, 8'hC3};
      flush_packet(1'b0, 1'b0);

      // burst of one-byte packets to fill the block during the long hold-off
      hold_at = byte_q.size();
      for (int i = 0; i < 24; i++) begin
         pkt_buf.push_back(8'($urandom));
         flush_packet(1'b0, 1'b1);
      end

      rand_items = byte_q.size();
      npkt = 0;
      while (rand_items < 650) begin
         r = $urandom_range(99);
         if (r < 35) len = $urandom_range(1, 4);
         else if (r < 80) len = $urandom_range(5, 16);
         else len = $urandom_range(17, 64);
         for (int i = 0; i < len; i++) begin
            r = $urandom_range(9);
            if (r == 0) pkt_buf.push_back(8'hFF);
            else if (r == 1) pkt_buf.push_back(8'h00);
            else pkt_buf.push_back(8'($urandom));
         end
         flush_packet(npkt % 12 == 11, $urandom_range(3) == 0);
         rand_items += len;
         npkt++;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (byte_q.size() != 0 || req_valid) @(posedge clock);
      while (csum_exp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (err_cnt == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/csum_pkg.sv
hdl/csum_acc.sv
hdl/csum_fold.sv
hdl/ones_complement_checksum_stream.sv
tb/tb_top.sv
